FILE: rtl/pccm_pkg.sv
// Shared constants and types for the pixel cluster centroid core.
package pccm_pkg;

   localparam int MaxHitsDefault   = 64;
   localparam int CoordBitsDefault = 10;
   localparam int FracBitsDefault  = 8;

   localparam int ColumnW = 10;
   localparam int RowW    = 10;
   localparam int LabelW  = 16;
   localparam int CenterW = 18;
   localparam int CountW  = 7;

   // Input beat packing: column, row, label (last_hit travels as tlast).
   localparam int ReqDataW = 40;
   // Result beat packing: column_center, row_center, majority_label, hit_count, overflow.
   localparam int RspDataW = 64;

   // One hit as handed from the front end to the back end.
   typedef struct packed {
      logic [ColumnW-1:0] column;
      logic [RowW-1:0]    row;
      logic [LabelW-1:0]  label;
      logic               last_hit;
   } hit_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_DIV,
      ST_OUT
   } seq_state_type;

endpackage

FILE: rtl/pccm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pccm_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/pccm_queue.sv
// Two-entry hit queue between the front end and the back end.
module pccm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pccm_pkg::hit_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output pccm_pkg::hit_type pop_data
);
   import pccm_pkg::*;

   hit_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = slot_ff[rd_ptr_ff];

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue pushed while full");
   a_no_underrun : assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("queue popped while empty");
   a_count_ok : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
endmodule

FILE: rtl/pccm_back.sv
// Back end: accumulates hits, tallies labels, finds the mode, divides.
module pccm_back #(
   parameter int MaxHits   = pccm_pkg::MaxHitsDefault,
   parameter int CoordBits = pccm_pkg::CoordBitsDefault,
   parameter int FracBits  = pccm_pkg::FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          skip_label,
   input  logic                          q_empty,
   input  pccm_pkg::hit_type             q_data,
   output logic                          q_pop,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic [pccm_pkg::CenterW-1:0]  res_col,
   output logic [pccm_pkg::CenterW-1:0]  res_row,
   output logic [pccm_pkg::LabelW-1:0]   res_label,
   output logic [pccm_pkg::CountW-1:0]   res_count,
   output logic                          res_ovf
);
   import pccm_pkg::*;

   localparam int AddrW  = (MaxHits > 1) ? $clog2(MaxHits) : 1;
   localparam int CntW   = $clog2(MaxHits + 1);
   localparam int SumW   = CoordBits + CntW;
   localparam int DivW   = SumW + FracBits;
   localparam int DivStW = $clog2(DivW + 1);

   seq_state_type state_ff, state_in;

   logic [SumW-1:0]  csum_ff, csum_in, rsum_ff, rsum_in;
   logic [CntW-1:0]  hits_ff, hits_in, dist_ff, dist_in;
   logic             drop_ff, drop_in;
   logic [AddrW-1:0] idx_ff, idx_in;
   logic [CntW-1:0]  ptr_ff, ptr_in;      // scan position, lags read address by one
   logic             hit_last_ff, hit_last_in;
   logic [LabelW-1:0] lab_ff, lab_in;
   logic [LabelW-1:0] best_ff, best_in;
   logic [CntW-1:0]  best_n_ff, best_n_in;
   logic [DivW-1:0]  qc_ff, qc_in, qr_ff, qr_in;
   logic [CntW:0]    rc_ff, rc_in, rr_ff, rr_in;
   logic [DivStW-1:0] dstep_ff, dstep_in;
   logic             found_ff, found_in;

   // RAM ports
   logic             st_we, ta_we;
   logic [AddrW-1:0] st_wa, ta_wa, rd_a;
   logic [LabelW-1:0] st_wd, st_rd;
   logic [CntW-1:0]  ta_wd, ta_rd;

   pccm_ram #(.Width(LabelW), .Depth(MaxHits)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(rd_a), .rd_data(st_rd));
   pccm_ram #(.Width(CntW), .Depth(MaxHits)) u_tally (
      .clock(clock), .wr_en(ta_we), .wr_addr(ta_wa), .wr_data(ta_wd),
      .rd_addr(rd_a), .rd_data(ta_rd));

   logic take, room;
   logic [CntW:0] tc, tr;
   assign room = hits_ff != CntW'(MaxHits);
   assign take = (state_ff == ST_IDLE) && !q_empty;
   assign tc = {rc_ff[CntW-1:0], qc_ff[DivW-1]};
   assign tr = {rr_ff[CntW-1:0], qr_ff[DivW-1]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            if (room && q_data.label != '0) state_in = ST_LOOK;
            else if (q_data.last_hit) state_in = ST_SCAN;
         end
         ST_LOOK: if (found_ff) begin
            state_in = hit_last_ff ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: if (ptr_ff == dist_ff) state_in = ST_DIV;
         ST_DIV:  if (dstep_ff == DivStW'(DivW)) state_in = ST_OUT;
         ST_OUT:  if (res_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      csum_in = csum_ff; rsum_in = rsum_ff; hits_in = hits_ff; dist_in = dist_ff;
      drop_in = drop_ff; idx_in = idx_ff; ptr_in = ptr_ff; hit_last_in = hit_last_ff;
      lab_in = lab_ff; best_in = best_ff; best_n_in = best_n_ff;
      qc_in = qc_ff; qr_in = qr_ff; rc_in = rc_ff; rr_in = rr_ff;
      dstep_in = dstep_ff; found_in = found_ff;
      st_we = 1'b0; ta_we = 1'b0; st_wa = dist_ff[AddrW-1:0]; ta_wa = dist_ff[AddrW-1:0];
      st_wd = lab_ff; ta_wd = CntW'(1); rd_a = idx_ff;
      q_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = take;
            rd_a = '0;
            if (take) begin
               hit_last_in = q_data.last_hit;
               lab_in = q_data.label;
               idx_in = AddrW'(1);
               ptr_in = '0;
               found_in = 1'b0;
               best_in = '0; best_n_in = '0;
               if (room) begin
                  csum_in = csum_ff + SumW'(q_data.column[CoordBits-1:0]);
                  rsum_in = rsum_ff + SumW'(q_data.row[CoordBits-1:0]);
                  hits_in = hits_ff + CntW'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         ST_LOOK: begin
            // ptr_ff is the entry whose data is on the RAM outputs.
            if (!found_ff) begin
               if (ptr_ff == dist_ff) begin
                  st_we = 1'b1; ta_we = 1'b1;
                  dist_in = dist_ff + CntW'(1);
                  found_in = 1'b1;
               end else if (st_rd == lab_ff) begin
                  ta_we = 1'b1; ta_wa = ptr_ff[AddrW-1:0]; ta_wd = ta_rd + CntW'(1);
                  found_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + CntW'(1);
                  idx_in = idx_ff + AddrW'(1);
               end
            end
            // Table write has landed; start the read of entry 0 for the scan.
            if (found_ff) begin
               rd_a = '0; idx_in = AddrW'(1); ptr_in = '0;
            end
         end
         ST_SCAN: begin
            if (ptr_ff != dist_ff) begin
               if (ta_rd > best_n_ff || (ta_rd == best_n_ff && st_rd < best_ff)) begin
                  best_in = st_rd; best_n_in = ta_rd;
               end
               ptr_in = ptr_ff + CntW'(1);
               idx_in = idx_ff + AddrW'(1);
            end else begin
               qc_in = DivW'(csum_ff) << FracBits;
               qr_in = DivW'(rsum_ff) << FracBits;
               rc_in = '0; rr_in = '0; dstep_in = '0;
            end
         end
         ST_DIV: begin
            // Restoring division, one quotient bit per cycle for each center.
            if (dstep_ff != DivStW'(DivW)) begin
               qc_in = {qc_ff[DivW-2:0], tc >= {1'b0, hits_ff}};
               rc_in = (tc >= {1'b0, hits_ff}) ? tc - {1'b0, hits_ff} : tc;
               qr_in = {qr_ff[DivW-2:0], tr >= {1'b0, hits_ff}};
               rr_in = (tr >= {1'b0, hits_ff}) ? tr - {1'b0, hits_ff} : tr;
               dstep_in = dstep_ff + DivStW'(1);
            end
         end
         ST_OUT: begin
            if (res_ready) begin
               csum_in = '0; rsum_in = '0; hits_in = '0; dist_in = '0; drop_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csum_ff <= '0; rsum_ff <= '0; hits_ff <= '0; dist_ff <= '0; drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         csum_ff <= csum_in; rsum_ff <= rsum_in; hits_ff <= hits_in;
         dist_ff <= dist_in; drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; ptr_ff <= ptr_in; hit_last_ff <= hit_last_in; lab_ff <= lab_in;
      best_ff <= best_in; best_n_ff <= best_n_in; qc_ff <= qc_in; qr_ff <= qr_in;
      rc_ff <= rc_in; rr_ff <= rr_in; dstep_ff <= dstep_in; found_ff <= found_in;
   end

   assign res_valid = state_ff == ST_OUT;
   assign res_col   = CenterW'(qc_ff);
   assign res_row   = CenterW'(qr_ff);
   assign res_label = skip_label ? '0 : best_ff;
   assign res_count = CountW'(hits_ff);
   assign res_ovf   = drop_ff;

   a_hits_cap : assert property (@(posedge clock) disable iff (reset)
      hits_ff <= CntW'(MaxHits)) else $error("hit count above capacity");
   a_dist_le_hits : assert property (@(posedge clock) disable iff (reset)
      dist_ff <= hits_ff) else $error("more labels than hits");
   a_clear_after_out : assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (hits_ff == '0 && !drop_ff))
      else $error("cluster not cleared after result");
   a_out_nonzero : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> hits_ff != '0) else $error("result with no hits");
endmodule

FILE: rtl/pccm_front.sv
// Front end: accepts hit beats, unpacks them and pushes them into the queue.
module pccm_front #(
   parameter int CoordBits = pccm_pkg::CoordBitsDefault
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pccm_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tlast,
   input  logic                          q_full,
   output logic                          q_push,
   output pccm_pkg::hit_type             q_data
);
   import pccm_pkg::*;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Keep only the coordinate bits in use; upper bits are dropped here.
   always_comb begin
      q_data.column   = ColumnW'(req_tdata[CoordBits-1:0]);
      q_data.row      = RowW'(req_tdata[ColumnW +: CoordBits]);
      q_data.label    = req_tdata[ColumnW+RowW +: LabelW];
      q_data.last_hit = req_tlast;
   end
endmodule

FILE: rtl/pixel_cluster_centroid_and_mode_core.sv
// Top level of the pixel cluster centroid and majority label core.
// Hits of one cluster arrive one beat each (column, row, label; tlast marks the
// last hit). The front end lands each beat in a two-entry queue; the back end
// adds column and row into running sums, then looks the label up in a label
// table held in RAM, walking the table one entry per cycle until the match or
// the free slot. Unlabeled and dropped hits skip the table walk. On the last hit
// the back end scans the table once for the most frequent label, smallest on
// ties, then runs a restoring divider producing one quotient bit per cycle for
// both centers, and holds the result beat until taken. Hits past MAX_HITS are
// dropped and flagged. skip_label is applied live while the result shows.
module pixel_cluster_centroid_and_mode_core #(
   parameter int MaxHits   = pccm_pkg::MaxHitsDefault,
   parameter int CoordBits = pccm_pkg::CoordBitsDefault,
   parameter int FracBits  = pccm_pkg::FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,   // skip_label
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [9:0] column, [19:10] row, [35:20] label, [39:36] zero
   input  logic [pccm_pkg::ReqDataW-1:0] req_tdata,
   input  logic                          req_tlast,     // last_hit
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [17:0] column_center, [35:18] row_center, [51:36] majority_label,
   // [58:52] hit_count, [59] overflow, [63:60] zero
   output logic [pccm_pkg::RspDataW-1:0] rsp_tdata
);
   import pccm_pkg::*;

   logic    skip_ff, skip_in;
   logic    q_full, q_push, q_empty, q_pop;
   hit_type q_in, q_out;
   logic [CenterW-1:0] col_c, row_c;
   logic [LabelW-1:0]  maj;
   logic [CountW-1:0]  cnt;
   logic               ovf;

   // Hold skip_label until rewritten.
   assign skip_in = csr_wr_en ? csr_wr_data : skip_ff;
   always_ff @(posedge clock) begin
      if (reset) skip_ff <= 1'b0;
      else       skip_ff <= skip_in;
   end

   pccm_front #(.CoordBits(CoordBits)) u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .q_full(q_full), .q_push(q_push), .q_data(q_in));

   pccm_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out));

   pccm_back #(.MaxHits(MaxHits), .CoordBits(CoordBits), .FracBits(FracBits)) u_back (
      .clock(clock), .reset(reset), .skip_label(skip_ff), .q_empty(q_empty),
      .q_data(q_out), .q_pop(q_pop), .res_valid(rsp_tvalid), .res_ready(rsp_tready),
      .res_col(col_c), .res_row(row_c), .res_label(maj), .res_count(cnt),
      .res_ovf(ovf));

   // Pack the result beat, lowest field first.
   assign rsp_tdata = {4'b0, ovf, cnt, maj, row_c, col_c};

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !csr_wr_en) |=> $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      req_tready == !q_full) else $error("ready not tied to queue space");
endmodule
